/* rtl/cwfp_pkg.sv */
// Package for the CRC-8 word-checked frame parser: payload structs, register
// indexes, reset values and the byte-wide CRC-8 update function.
// Depends on nothing.
package cwfp_pkg;

  localparam int unsigned FrameBytes = 12;
  localparam int unsigned PosW       = 4;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [7:0] CrcInitReset = 8'hFF;
  localparam logic [7:0] CrcPolyReset = 8'h31;
  localparam logic [7:0] CrcMsb       = 8'h80;

  localparam logic [PosW-1:0] PosLast = PosW'(FrameBytes - 1);
  localparam logic [PosW-1:0] PosHalf = PosW'(FrameBytes / 2);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CRC_INIT = 2'd0,
    CFG_CRC_POLY = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [31:0] first_value_bits;
    logic [31:0] second_value_bits;
    logic        frame_status;
  } out_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcMsb) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // True for the CRC byte of each three-byte group.
  function automatic logic is_crc_slot(input logic [PosW-1:0] pos);
    logic r;
    case (pos)
      4'd2, 4'd5, 4'd8, 4'd11: r = 1'b1;
      default:                 r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/crc8_word_checked_frame_parser.sv */
// CRC-8 word-checked frame parser, top level.
// Depends on cwfp_pkg for payload structs, register indexes and the CRC function.
//
// Usage: bytes of a twelve-byte measurement response arrive one per transfer on
// the in_ channel (valid/ready). Each group of three bytes is two data bytes
// followed by their CRC-8 (MSB first, init and polynomial from registers 0 and
// 1 of the cfg_ port). frame_start on a byte makes it position 0 and drops any
// partial frame. On the twelfth byte one result leaves on the out_ channel:
// data bytes 0..3 and 4..7 assembled big-endian, and a status bit set when any
// group failed its check. Value bits are passed through even on error.
// Throughput is one byte per cycle; the CRC of a byte is an unrolled
// eight-step update between the input register and the state registers.
// A result is registered: its twelfth byte moves from the input register to the
// result register. While the result register is held by a stalled receiver,
// bytes that produce no result still flow; a twelfth byte waits in the input
// register until the result register frees up, and in_ready stays low meanwhile.
// Reset (synchronous, active low) empties both stages, sets the byte position
// to 0 and restores the register reset values (init 0xFF, polynomial 0x31).
// The configuration port is always ready; the user must write it only while idle (not enforced).
module crc8_word_checked_frame_parser
  import cwfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_data
);

  logic            s1_valid_r, s1_valid_nxt;
  in_t             s1_data_r;
  logic [7:0]      crc_init_r, crc_poly_r;
  logic [PosW-1:0] pos_r, pos_nxt, pos_cur;
  logic [7:0]      run_crc_r, run_crc_nxt;
  logic            crc_fail_r, crc_fail_nxt, fail_cur;
  logic [31:0]     acc1_r, acc1_nxt, acc1_cur;
  logic [31:0]     acc2_r, acc2_nxt, acc2_cur;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_data_r;
  logic            is_last, s1_go, res_load;
  logic [7:0]      seed;

  assign cfg_ready = 1'b1;

  always_comb begin
    pos_cur  = s1_data_r.frame_start ? '0 : pos_r;
    if (pos_cur > PosLast) begin
      pos_cur = '0;
    end
    fail_cur = s1_data_r.frame_start ? 1'b0 : crc_fail_r;
    acc1_cur = s1_data_r.frame_start ? 32'h0 : acc1_r;
    acc2_cur = s1_data_r.frame_start ? 32'h0 : acc2_r;
    is_last  = (pos_cur == PosLast);
    seed     = (pos_cur == 4'd0 || pos_cur == 4'd3 || pos_cur == 4'd6 || pos_cur == 4'd9)
               ? crc_init_r : run_crc_r;

    crc_fail_nxt = fail_cur;
    run_crc_nxt  = run_crc_r;
    acc1_nxt     = acc1_cur;
    acc2_nxt     = acc2_cur;
    if (is_crc_slot(pos_cur)) begin
      if (s1_data_r.rx_byte != run_crc_r) begin
        crc_fail_nxt = 1'b1;
      end
      run_crc_nxt = crc_init_r;
    end else begin
      run_crc_nxt = crc8_byte(seed, s1_data_r.rx_byte, crc_poly_r);
      if (pos_cur < PosHalf) begin
        acc1_nxt = {acc1_cur[23:0], s1_data_r.rx_byte};
      end else begin
        acc2_nxt = {acc2_cur[23:0], s1_data_r.rx_byte};
      end
    end
    pos_nxt = is_last ? '0 : pos_cur + 1'b1;
  end

  assign s1_go         = s1_valid_r && (!is_last || !out_valid_r || out_ready);
  assign res_load      = s1_go && is_last;
  assign in_ready      = !s1_valid_r || s1_go;
  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !s1_go);
  assign out_valid_nxt = res_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_init_r  <= CrcInitReset;
      crc_poly_r  <= CrcPolyReset;
      pos_r       <= '0;
      run_crc_r   <= CrcInitReset;
      crc_fail_r  <= 1'b0;
      acc1_r      <= 32'h0;
      acc2_r      <= 32'h0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CRC_INIT: crc_init_r <= cfg_data;
          CFG_CRC_POLY: crc_poly_r <= cfg_data;
          default:      ;
        endcase
      end
      if (s1_go) begin
        pos_r      <= pos_nxt;
        run_crc_r  <= run_crc_nxt;
        crc_fail_r <= is_last ? 1'b0 : crc_fail_nxt;
        acc1_r     <= acc1_nxt;
        acc2_r     <= acc2_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (res_load) begin
      out_data_r.first_value_bits  <= acc1_nxt;
      out_data_r.second_value_bits <= acc2_nxt;
      out_data_r.frame_status      <= crc_fail_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PosLast)
    else $error("byte position out of frame range");

  a_end_of_frame: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (pos_r == '0) && !crc_fail_r && out_valid_r)
    else $error("frame end did not restart position and present a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !res_load)
    else $error("result register overwritten while held");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> s1_valid_r && $stable(s1_data_r))
    else $error("stalled byte lost from input register");

endmodule

/* tb/sv/crc8_word_checked_frame_parser_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for crc8_word_checked_frame_parser: a scoreboard class that
// predicts frame results from accepted bytes, and tasks that drive bytes and registers.
// Depends on cwfp_pkg and the parser RTL.

class frame_scoreboard;
  logic [7:0]                     crc_init;
  logic [7:0]                     crc_poly;
  logic [cwfp_pkg::PosW-1:0]      byte_pos;
  logic [7:0]                     run_crc;
  logic                           crc_bad;
  logic [31:0]                    first_acc;
  logic [31:0]                    second_acc;
  cwfp_pkg::out_t                 frame_q[$];
  int                             errors;

  function new();
    crc_init   = cwfp_pkg::CrcInitReset;
    crc_poly   = cwfp_pkg::CrcPolyReset;
    byte_pos   = '0;
    run_crc    = cwfp_pkg::CrcInitReset;
    crc_bad    = 1'b0;
    first_acc  = '0;
    second_acc = '0;
    errors     = 0;
  endfunction

  function logic [7:0] crc_update(logic [7:0] seed, logic [7:0] data, logic [7:0] poly);
    logic [7:0] c;
    c = seed ^ data;
    repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
    return c;
  endfunction

  function void write_reg(logic [cwfp_pkg::CfgIdxW-1:0] idx, logic [7:0] val);
    if (idx == cwfp_pkg::CFG_CRC_INIT) begin
      crc_init = val;
    end else if (idx == cwfp_pkg::CFG_CRC_POLY) begin
      crc_poly = val;
    end
  endfunction

  function int pending();
    return frame_q.size();
  endfunction

  function void note_byte(cwfp_pkg::in_t item);
    logic [cwfp_pkg::PosW-1:0] p;
    int                        slot;
    cwfp_pkg::out_t            res;
    if (item.frame_start) begin
      byte_pos   = '0;
      crc_bad    = 1'b0;
      first_acc  = '0;
      second_acc = '0;
    end
    p    = (byte_pos > cwfp_pkg::PosLast) ? '0 : byte_pos;
    slot = p % 3;
    if (slot == 2) begin
      if (item.rx_byte != run_crc) crc_bad = 1'b1;
      run_crc = crc_init;
    end else begin
      run_crc = crc_update((slot == 0) ? crc_init : run_crc, item.rx_byte, crc_poly);
      if (p < cwfp_pkg::PosHalf) begin
        first_acc = {first_acc[23:0], item.rx_byte};
      end else begin
        second_acc = {second_acc[23:0], item.rx_byte};
      end
    end
    if (p == cwfp_pkg::PosLast) begin
      res.first_value_bits  = first_acc;
      res.second_value_bits = second_acc;
      res.frame_status      = crc_bad;
      frame_q.push_back(res);
      byte_pos = '0;
      crc_bad  = 1'b0;
    end else begin
      byte_pos = p + 1'b1;
    end
  endfunction

  task report(string msg);
    errors++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task check_result(cwfp_pkg::out_t got);
    cwfp_pkg::out_t want;
    if (frame_q.size() == 0) begin
      report($sformatf("result %h arrived with none expected", got));
    end else begin
      want = frame_q.pop_front();
      if (got.first_value_bits !== want.first_value_bits)
        report($sformatf("first_value_bits %h, expected %h",
                         got.first_value_bits, want.first_value_bits));
      if (got.second_value_bits !== want.second_value_bits)
        report($sformatf("second_value_bits %h, expected %h",
                         got.second_value_bits, want.second_value_bits));
      if (got.frame_status !== want.frame_status)
        report($sformatf("frame_status %b, expected %b",
                         got.frame_status, want.frame_status));
    end
  endtask
endclass

module crc8_word_checked_frame_parser_tb;
  import cwfp_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned PhaseItems  = 250;
  localparam int unsigned PhaseCount  = 6;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_t                in_data;
  logic               out_valid;
  logic               out_ready;
  out_t               out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [7:0]         cfg_data;

  frame_scoreboard sb = new();
  int unsigned     cycles;
  int unsigned     items;
  bit              tx_burst;
  bit              rx_burst;
  int              rx_stall;

  crc8_word_checked_frame_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("** crc8_word_checked_frame_parser: FAILED **");
      $finish;
    end
  end

  // Outside bursts the receiver holds off for a drawn number of cycles during which a result is offered.
  initial begin
    out_ready <= 1'b0;
    rx_burst  = 1'b0;
    rx_stall  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        sb.check_result(out_data);
        if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
        rx_stall = rx_burst ? 0 : $urandom_range(0, 10);
        out_ready <= (rx_stall == 0);
      end else if (rx_stall > 0) begin
        if (out_valid) rx_stall--;
        out_ready <= (rx_stall == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic start);
    int   gap;
    in_t  item;
    item.rx_byte     = value;
    item.frame_start = start;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(item);
    items++;
  endtask

  // Sends the first len bytes of a frame built from eight data bytes, with the CRC byte
  // of each group flagged in bad_groups deliberately spoilt.
  task automatic send_frame(input logic [63:0] data, input logic [3:0] bad_groups,
                            input int len, input logic start);
    logic [7:0] frame_bytes [12];
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] chk;
    for (int g = 0; g < 4; g++) begin
      d0  = data[63 - 16 * g -: 8];
      d1  = data[55 - 16 * g -: 8];
      chk = sb.crc_update(sb.crc_update(sb.crc_init, d0, sb.crc_poly), d1, sb.crc_poly);
      if (bad_groups[g]) chk ^= 8'($urandom_range(1, 255));
      frame_bytes[3 * g]     = d0;
      frame_bytes[3 * g + 1] = d1;
      frame_bytes[3 * g + 2] = chk;
    end
    for (int k = 0; k < len; k++) send_byte(frame_bytes[k], (k == 0) ? start : 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed frames; the rest are spoilt, cut short or plain noise.
  task automatic random_burst();
    int          kind;
    int          n;
    logic [63:0] data;
    logic        start;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 4) == 0) tx_burst = !tx_burst;
    data = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) data = $urandom_range(0, 1) ? '1 : '0;
    start = (sb.byte_pos != 0) || ($urandom_range(0, 1) == 1);
    if (kind < 70) begin
      send_frame(data, 4'b0000, 12, start);
    end else if (kind < 82) begin
      send_frame(data, 4'($urandom_range(1, 15)), 12, start);
    end else if (kind < 92) begin
      send_frame(data, 4'($urandom_range(0, 15)), $urandom_range(1, 11), start);
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
    if ($urandom_range(0, 39) == 0) wait_drained();
  endtask

  initial begin
    logic [7:0] new_init;
    logic [7:0] new_poly;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_CRC_INIT;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    items     = 0;
    tx_burst  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extreme data under the reset settings, a frame that restarts on its own after the
    // previous one, a partial frame dropped by a start flag, and spoilt CRC bytes.
    send_frame(64'hFFFF_0000_8001_7FFE, 4'b0000, 12, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'h56, 1'b0);
    send_frame(64'h0000_FFFF_A5A5_5A5A, 4'b1001, 12, 1'b1);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      if (phase > 0) begin
        wait_drained();
        repeat (4) @(posedge clk);
        case (phase)
          1:       begin new_init = 8'h00; new_poly = 8'h00; end
          2:       begin new_init = 8'hFF; new_poly = 8'hFF; end
          3:       begin new_init = 8'h00; new_poly = 8'h31; end
          default: begin
            new_init = 8'($urandom_range(0, 255));
            new_poly = 8'($urandom_range(0, 255));
          end
        endcase
        cfg_write(phase[0] ? CfgSpareLo : CfgSpareHi, 8'($urandom_range(0, 255)));
        cfg_write(CFG_CRC_POLY, new_poly);
        cfg_write(CFG_CRC_INIT, new_init);
      end
      while (items < (phase + 1) * PhaseItems) random_burst();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** crc8_word_checked_frame_parser: PASSED **");
    end else begin
      $display("** crc8_word_checked_frame_parser: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/cwfp_pkg.sv
rtl/crc8_word_checked_frame_parser.sv
tb/sv/crc8_word_checked_frame_parser_tb.sv
